[hw/rtl/set_function_modularity_checker_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the set function modularity checker
// Shared concurrent assertion forms, clocked on clock and off during reset.
// ----------------------------------------------------------------------------
`ifndef SET_FUNCTION_MODULARITY_CHECKER_TOP_ASSERT_SVH
`define SET_FUNCTION_MODULARITY_CHECKER_TOP_ASSERT_SVH

// Same-cycle implication
`define SFMC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sfmc assertion failed");

// Next-cycle implication
`define SFMC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sfmc assertion failed");

`endif

[hw/rtl/sfmc_pkg.sv]
// ----------------------------------------------------------------------------
// sfmc_pkg
// Types, codes and size defaults for the set function modularity checker.
// ----------------------------------------------------------------------------
package sfmc_pkg;

   // Default sizes
   localparam int MAX_VARIABLES_DEFAULT = 8;
   localparam int VALUE_BITS_DEFAULT    = 32;

   // Fixed port widths
   localparam int FUNC_VALUE_W = 32;
   localparam int SET_W        = 8;
   localparam int MODE_W       = 2;
   localparam int NVAR_W       = 4;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 4;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CHECK_MODE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_VARIABLES = 2'd1;

   // Check modes
   localparam logic [MODE_W-1:0] MODE_SUBMODULAR   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SUPERMODULAR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_POSIMODULAR  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NEGIMODULAR  = 2'd3;

   // Register reset values
   localparam logic [MODE_W-1:0] CHECK_MODE_RESET    = MODE_SUBMODULAR;
   localparam logic [NVAR_W-1:0] NUM_VARIABLES_RESET = 4'd2;

   // One result item
   typedef struct packed {
      logic             holds;
      logic [SET_W-1:0] first_set;
      logic [SET_W-1:0] second_set;
   } sfmc_result_type;

endpackage

[hw/rtl/sfmc_table.sv]
// ----------------------------------------------------------------------------
// sfmc_table
// Value memory: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module sfmc_table import sfmc_pkg::*; #(
   parameter int ADDR_BITS = MAX_VARIABLES_DEFAULT,
   parameter int DATA_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr_a,
   input  logic [ADDR_BITS-1:0] rd_addr_b,
   output logic [DATA_BITS-1:0] rd_data_a,
   output logic [DATA_BITS-1:0] rd_data_b
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_a_ff;
   logic [DATA_BITS-1:0] rd_b_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read two entries into registered outputs
   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[hw/rtl/sfmc_walk.sv]
// ----------------------------------------------------------------------------
// sfmc_walk
// Pair walker: issues table reads for each pair and compares the two sums.
// ----------------------------------------------------------------------------
module sfmc_walk import sfmc_pkg::*; #(
   parameter int MAX_VARIABLES = MAX_VARIABLES_DEFAULT,
   parameter int VALUE_BITS    = VALUE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     go,
   input  logic [MAX_VARIABLES-1:0] top_idx,
   input  logic [MODE_W-1:0]        check_mode,
   output logic [MAX_VARIABLES-1:0] rd_addr_a,
   output logic [MAX_VARIABLES-1:0] rd_addr_b,
   input  logic [VALUE_BITS-1:0]    rd_data_a,
   input  logic [VALUE_BITS-1:0]    rd_data_b,
   output logic                     done,
   output sfmc_result_type          result
);

   `include "set_function_modularity_checker_top_assert.svh"

   logic                         run_ff, run_in;
   logic                         ph_ff, ph_in;
   logic [MAX_VARIABLES-1:0]     lo_ff, lo_in;
   logic [MAX_VARIABLES-1:0]     hi_ff, hi_in;
   logic [MAX_VARIABLES-1:0]     top_ff, top_in;
   logic                         cmp_v_ff, cmp_v_in;
   logic                         cmp_last_ff, cmp_last_in;
   logic [MAX_VARIABLES-1:0]     cmp_lo_ff, cmp_lo_in;
   logic [MAX_VARIABLES-1:0]     cmp_hi_ff, cmp_hi_in;
   logic signed [VALUE_BITS:0]   lhs_ff, lhs_in;
   logic                         done_ff, done_in;
   sfmc_result_type              result_ff, result_in;

   logic                         lattice;
   logic                         greater;
   logic signed [VALUE_BITS:0]   pair_sum;
   logic                         bad;
   logic                         last_pair;
   logic [MAX_VARIABLES+7:0]     lo_ext;
   logic [MAX_VARIABLES+7:0]     hi_ext;

   assign lattice = (check_mode == MODE_SUBMODULAR) || (check_mode == MODE_SUPERMODULAR);
   assign greater = (check_mode == MODE_SUPERMODULAR) || (check_mode == MODE_NEGIMODULAR);

   // Address the pair itself, then its meet and join (or differences)
   always_comb begin
      if (!ph_ff) begin
         rd_addr_a = lo_ff;
         rd_addr_b = hi_ff;
      end else if (lattice) begin
         rd_addr_a = lo_ff & hi_ff;
         rd_addr_b = lo_ff | hi_ff;
      end else begin
         rd_addr_a = lo_ff & ~hi_ff;
         rd_addr_b = hi_ff & ~lo_ff;
      end
   end

   // Exact sum of the two read values
   assign pair_sum = $signed({rd_data_a[VALUE_BITS-1], rd_data_a})
                   + $signed({rd_data_b[VALUE_BITS-1], rd_data_b});

   assign bad = cmp_v_ff && (greater ? (lhs_ff > pair_sum) : (lhs_ff < pair_sum));

   assign last_pair = (hi_ff == top_ff) && ((lo_ff + 1'b1) == top_ff);

   // Low eight bits of the reported masks
   assign lo_ext = {8'd0, cmp_lo_ff};
   assign hi_ext = {8'd0, cmp_hi_ff};

   // Next state of the walk
   always_comb begin
      run_in      = run_ff;
      ph_in       = ph_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      top_in      = top_ff;
      cmp_v_in    = 1'b0;
      cmp_last_in = cmp_last_ff;
      cmp_lo_in   = cmp_lo_ff;
      cmp_hi_in   = cmp_hi_ff;
      lhs_in      = lhs_ff;
      done_in     = 1'b0;
      result_in   = result_ff;

      if (go) begin
         run_in = 1'b1;
         ph_in  = 1'b0;
         lo_in  = '0;
         hi_in  = MAX_VARIABLES'(1);
         top_in = top_idx;
      end else if (bad) begin
         // Drop the rest of the walk on the first violation
         run_in               = 1'b0;
         ph_in                = 1'b0;
         done_in              = 1'b1;
         result_in.holds      = 1'b0;
         result_in.first_set  = lo_ext[SET_W-1:0];
         result_in.second_set = hi_ext[SET_W-1:0];
      end else begin
         if (cmp_v_ff && cmp_last_ff) begin
            done_in              = 1'b1;
            result_in.holds      = 1'b1;
            result_in.first_set  = '0;
            result_in.second_set = '0;
         end
         if (run_ff) begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               // Pair sum read back: hold it and advance to the next pair
               lhs_in      = pair_sum;
               cmp_v_in    = 1'b1;
               cmp_last_in = last_pair;
               cmp_lo_in   = lo_ff;
               cmp_hi_in   = hi_ff;
               if (last_pair) begin
                  run_in = 1'b0;
               end else if (hi_ff == top_ff) begin
                  lo_in = lo_ff + 1'b1;
                  hi_in = lo_ff + MAX_VARIABLES'(2);
               end else begin
                  hi_in = hi_ff + 1'b1;
               end
            end
         end
      end
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         ph_ff    <= 1'b0;
         cmp_v_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         run_ff   <= run_in;
         ph_ff    <= ph_in;
         cmp_v_ff <= cmp_v_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      top_ff      <= top_in;
      cmp_last_ff <= cmp_last_in;
      cmp_lo_ff   <= cmp_lo_in;
      cmp_hi_ff   <= cmp_hi_in;
      lhs_ff      <= lhs_in;
      result_ff   <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

   // A result follows a comparison in the cycle before
   `SFMC_ASSERT_IMPL(a_done_after_cmp, done_ff, $past(cmp_v_ff))
   // Comparisons never come back to back
   `SFMC_ASSERT_NEXT(a_cmp_spacing, cmp_v_ff, !cmp_v_ff)
   // The walk only visits ordered pairs
   `SFMC_ASSERT_IMPL(a_pair_order, run_ff && !ph_ff, hi_ff > lo_ff)

endmodule

[hw/rtl/set_function_modularity_checker_top.sv]
// ----------------------------------------------------------------------------
// set_function_modularity_checker_top
// Loads a pseudo-Boolean function table and checks one modularity property.
// ----------------------------------------------------------------------------
// Usage:
//   Configure check_mode (index 0) and num_variables (index 1) through the
//   csr_ write port while the block is idle. Then present 2^n values on
//   req_func_value, one per start pulse, in subset-mask order; an item is
//   taken when start is high and busy is low, so loading runs one item per
//   cycle. The value for mask k lands in table entry k.
//   The last value raises busy and starts the pair walk over the table
//   memory. Each pair (lower < upper) is read on the memory's two read
//   ports, first the pair itself, then its meet and join (or differences);
//   there are S*(S-1)/2 pairs for S = 2^n entries, and a violation ends the
//   walk early. The result is shown for one cycle with rsp_valid high:
//   rsp_holds, or the first violating pair on rsp_first_set/rsp_second_set.
//   The receiver cannot stall. busy drops the cycle after the result.
//   Reset clears the registers to their reset values and the load count;
//   table contents are left as they are and are only read once written.
// ----------------------------------------------------------------------------
module set_function_modularity_checker_top import sfmc_pkg::*; #(
   parameter int MAX_VARIABLES = MAX_VARIABLES_DEFAULT,
   parameter int VALUE_BITS    = VALUE_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [FUNC_VALUE_W-1:0] req_func_value,
   output logic                           rsp_valid,
   output logic                           rsp_holds,
   output logic [SET_W-1:0]               rsp_first_set,
   output logic [SET_W-1:0]               rsp_second_set,
   input  logic                           csr_we,
   input  logic [CSR_INDEX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_wdata
);

   localparam int CNT_W = MAX_VARIABLES + 1;

   logic [MODE_W-1:0]        mode_ff, mode_in;
   logic [NVAR_W-1:0]        nvar_ff, nvar_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     busy_ff, busy_in;

   logic                     accept;
   logic [CNT_W-1:0]         count_next;
   logic                     fire;
   logic [NVAR_W:0]          n_clamp;
   logic [MAX_VARIABLES-1:0] top_idx;
   logic [VALUE_BITS-1:0]    wr_value;

   logic [MAX_VARIABLES-1:0] rd_addr_a;
   logic [MAX_VARIABLES-1:0] rd_addr_b;
   logic [VALUE_BITS-1:0]    rd_data_a;
   logic [VALUE_BITS-1:0]    rd_data_b;
   logic                     walk_done;
   sfmc_result_type          walk_result;

   assign accept = start && !busy_ff;

   // Clamp the variable count into 1..MAX_VARIABLES
   always_comb begin
      if (nvar_ff == '0) begin
         n_clamp = (NVAR_W+1)'(1);
      end else if ({1'b0, nvar_ff} > (NVAR_W+1)'(MAX_VARIABLES)) begin
         n_clamp = (NVAR_W+1)'(MAX_VARIABLES);
      end else begin
         n_clamp = {1'b0, nvar_ff};
      end
   end

   // Highest table index: n low ones
   always_comb begin
      for (int i = 0; i < MAX_VARIABLES; i++) begin
         top_idx[i] = ((NVAR_W+1)'(i) < n_clamp);
      end
   end

   assign count_next = count_ff + 1'b1;
   assign fire       = accept && (count_next > {1'b0, top_idx});

   // Narrow or sign-extend the incoming value to the table width
   generate
      if (VALUE_BITS <= FUNC_VALUE_W) begin : g_narrow
         assign wr_value = req_func_value[VALUE_BITS-1:0];
      end else begin : g_wide
         assign wr_value = {{(VALUE_BITS-FUNC_VALUE_W){req_func_value[FUNC_VALUE_W-1]}},
                            req_func_value};
      end
   endgenerate

   // Configuration writes, load count and busy flag
   always_comb begin
      mode_in  = mode_ff;
      nvar_in  = nvar_ff;
      count_in = count_ff;
      busy_in  = busy_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_CHECK_MODE:    mode_in = csr_wdata[MODE_W-1:0];
            CSR_NUM_VARIABLES: nvar_in = csr_wdata[NVAR_W-1:0];
            default:           ;
         endcase
      end

      if (fire) begin
         count_in = '0;
         busy_in  = 1'b1;
      end else if (accept) begin
         count_in = count_next;
      end else if (walk_done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= CHECK_MODE_RESET;
         nvar_ff  <= NUM_VARIABLES_RESET;
         count_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         nvar_ff  <= nvar_in;
         count_ff <= count_in;
         busy_ff  <= busy_in;
      end
   end

   sfmc_table #(
      .ADDR_BITS (MAX_VARIABLES),
      .DATA_BITS (VALUE_BITS)
   ) u_table (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (count_ff[MAX_VARIABLES-1:0]),
      .wr_data   (wr_value),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   sfmc_walk #(
      .MAX_VARIABLES (MAX_VARIABLES),
      .VALUE_BITS    (VALUE_BITS)
   ) u_walk (
      .clock      (clock),
      .reset      (reset),
      .go         (fire),
      .top_idx    (top_idx),
      .check_mode (mode_ff),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b),
      .rd_data_a  (rd_data_a),
      .rd_data_b  (rd_data_b),
      .done       (walk_done),
      .result     (walk_result)
   );

   assign busy           = busy_ff;
   assign rsp_valid      = walk_done;
   assign rsp_holds      = walk_result.holds;
   assign rsp_first_set  = walk_result.first_set;
   assign rsp_second_set = walk_result.second_set;

endmodule

[dv/set_function_modularity_checker_top_tb.sv]
// ----------------------------------------------------------------------------
// set_function_modularity_checker_top_tb
// Self-checking bench for the modularity checker. A short table of directed
// items covers every check mode, the value extremes, the out-of-range and
// ignored register writes, and a table resized in the middle of a load. A
// random part follows with modular functions, small bumps and noise. Typed
// rows carry their own verdict; every other verdict is checked against an
// in-bench predictor of the table and the walk.
// ----------------------------------------------------------------------------
module set_function_modularity_checker_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sfmc_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 6;
   localparam int RANDOM_ITEMS  = 1100;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int SETTLE_CYCLES = 4;
   localparam int END_CYCLES    = 20;
   localparam int TABLE_DEPTH   = 1 << MAX_VARIABLES_DEFAULT;

   localparam logic signed [FUNC_VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [FUNC_VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

   // Indexes past the register list; writes to them are dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type                   kind;
      logic [CSR_INDEX_W-1:0]         index;
      logic [CSR_DATA_W-1:0]          data;
      logic signed [FUNC_VALUE_W-1:0] value;
      bit                             typed;
      sfmc_result_type                verdict;
   } stim_row_type;

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic signed [FUNC_VALUE_W-1:0] req_func_value;
   logic                           rsp_valid;
   logic                           rsp_holds;
   logic [SET_W-1:0]               rsp_first_set;
   logic [SET_W-1:0]               rsp_second_set;
   logic                           csr_we;
   logic [CSR_INDEX_W-1:0]         csr_index;
   logic [CSR_DATA_W-1:0]          csr_wdata;

   // Predictor copy of the registers, the load count and the value table
   logic [MODE_W-1:0]              cfg_mode = CHECK_MODE_RESET;
   logic [NVAR_W-1:0]              cfg_nvar = NUM_VARIABLES_RESET;
   int                             loaded_count = 0;
   logic signed [FUNC_VALUE_W-1:0] fn_table [TABLE_DEPTH];

   sfmc_result_type expected_verdicts [$];
   stim_row_type    directed_rows [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int burst_left     = 0;
   bit no_idle        = 1'b0;

   set_function_modularity_checker_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func_value (req_func_value),
      .rsp_valid      (rsp_valid),
      .rsp_holds      (rsp_holds),
      .rsp_first_set  (rsp_first_set),
      .rsp_second_set (rsp_second_set),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // Clamp the variable count and return the number of table entries
   function automatic int table_entries(input logic [NVAR_W-1:0] nvar);
      int n;
      n = int'(nvar);
      if (n < 1) n = 1;
      if (n > MAX_VARIABLES_DEFAULT) n = MAX_VARIABLES_DEFAULT;
      return 1 << n;
   endfunction

   // Store one value; on a full table walk all pairs and queue the verdict
   function automatic void load_and_judge(input logic signed [FUNC_VALUE_W-1:0] v);
      int              entries;
      int              ia;
      int              ib;
      longint          lhs;
      longint          rhs;
      bit              meet_join;
      bit              below;
      bit              bad;
      sfmc_result_type verdict;
      entries = table_entries(cfg_nvar);
      fn_table[loaded_count % TABLE_DEPTH] = v;
      loaded_count++;
      if (loaded_count < entries) return;
      loaded_count = 0;
      meet_join = (cfg_mode == MODE_SUBMODULAR) || (cfg_mode == MODE_SUPERMODULAR);
      below     = (cfg_mode == MODE_SUBMODULAR) || (cfg_mode == MODE_POSIMODULAR);
      for (int lo = 0; lo < entries - 1; lo++) begin
         for (int hi = lo + 1; hi < entries; hi++) begin
            if (meet_join) begin
               ia = lo & hi;
               ib = lo | hi;
            end else begin
               ia = lo & ~hi;
               ib = hi & ~lo;
            end
            // sums are exact: no wrap at the value width
            lhs = longint'(fn_table[lo]) + longint'(fn_table[hi]);
            rhs = longint'(fn_table[ia]) + longint'(fn_table[ib]);
            bad = below ? (lhs < rhs) : (lhs > rhs);
            if (bad) begin
               verdict.holds      = 1'b0;
               verdict.first_set  = SET_W'(lo);
               verdict.second_set = SET_W'(hi);
               expected_verdicts.push_back(verdict);
               return;
            end
         end
      end
      verdict.holds      = 1'b1;
      verdict.first_set  = '0;
      verdict.second_set = '0;
      expected_verdicts.push_back(verdict);
   endfunction

   // Drop start and hold off until every verdict is in and the block is idle
   task automatic wait_until_drained();
      @(negedge clock);
      start = 1'b0;
      while (expected_verdicts.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register while the block is idle
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0]  data);
      wait_until_drained();
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      if (idx == CSR_CHECK_MODE) begin
         cfg_mode = data[MODE_W-1:0];
      end else if (idx == CSR_NUM_VARIABLES) begin
         cfg_nvar = data[NVAR_W-1:0];
      end
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Send one item in bursts with random gaps, then predict its effect
   task automatic put_item(input logic signed [FUNC_VALUE_W-1:0] v);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = (no_idle || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         repeat (gap) begin
            @(negedge clock);
            start = 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      start          = 1'b1;
      req_func_value = v;
      // hold the item until the block takes it
      do @(posedge clock); while (busy !== 1'b0);
      load_and_judge(v);
   endtask

   task automatic add_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0]  data);
      stim_row_type row;
      row.kind    = ROW_WRITE;
      row.index   = idx;
      row.data    = data;
      row.value   = '0;
      row.typed   = 1'b0;
      row.verdict = '0;
      directed_rows.push_back(row);
   endtask

   task automatic add_value(input logic signed [FUNC_VALUE_W-1:0] v);
      stim_row_type row;
      row.kind    = ROW_ITEM;
      row.index   = '0;
      row.data    = '0;
      row.value   = v;
      row.typed   = 1'b0;
      row.verdict = '0;
      directed_rows.push_back(row);
   endtask

   task automatic add_value_verdict(input logic signed [FUNC_VALUE_W-1:0] v,
                                    input logic holds,
                                    input logic [SET_W-1:0] first_set,
                                    input logic [SET_W-1:0] second_set);
      stim_row_type row;
      row.kind               = ROW_ITEM;
      row.index              = '0;
      row.data               = '0;
      row.value              = v;
      row.typed              = 1'b1;
      row.verdict.holds      = holds;
      row.verdict.first_set  = first_set;
      row.verdict.second_set = second_set;
      directed_rows.push_back(row);
   endtask

   // Sample the verdict at the rising edge, compare at the falling edge
   always begin
      logic             got_valid;
      logic             got_holds;
      logic [SET_W-1:0] got_first;
      logic [SET_W-1:0] got_second;
      sfmc_result_type  want;
      @(posedge clock);
      got_valid  = rsp_valid & ~reset;
      got_holds  = rsp_holds;
      got_first  = rsp_first_set;
      got_second = rsp_second_set;
      @(negedge clock);
      if (got_valid === 1'b1) begin
         if (expected_verdicts.size() == 0) begin
            $error("unexpected verdict: holds %0b first_set %0d second_set %0d",
                   got_holds, got_first, got_second);
            mismatch_count++;
         end else begin
            want = expected_verdicts.pop_front();
            if (got_holds !== want.holds) begin
               $error("holds: expected %0b, got %0b", want.holds, got_holds);
               mismatch_count++;
            end
            if (got_first !== want.first_set) begin
               $error("first_set: expected %0d, got %0d", want.first_set, got_first);
               mismatch_count++;
            end
            if (got_second !== want.second_set) begin
               $error("second_set: expected %0d, got %0d", want.second_set, got_second);
               mismatch_count++;
            end
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("set_function_modularity_checker_top_tb NOT OK");
         $finish;
      end
   end

   initial begin
      logic [MODE_W-1:0]              phase_mode;
      logic [NVAR_W-1:0]              phase_nvar;
      int                             random_items;
      int                             phase;
      int                             entries;
      int                             scale;
      int                             bump_mask;
      bit                             noise;
      bit                             bumped;
      longint                         base;
      longint                         bump;
      longint                         acc;
      longint                         weight [MAX_VARIABLES_DEFAULT];
      logic signed [FUNC_VALUE_W-1:0] fval;

      reset          = 1'b1;
      start          = 1'b0;
      req_func_value = '0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;

      // Directed table; reset leaves submodular mode over two variables
      add_value(0);
      add_value(0);
      add_value(0);
      add_value_verdict(1, 1'b0, 8'd1, 8'd2);
      // extremes: the sums overflow 32 bits
      add_write(CSR_CHECK_MODE, CSR_DATA_W'(MODE_SUPERMODULAR));
      add_value(VALUE_MIN);
      add_value(VALUE_MAX);
      add_value(VALUE_MAX);
      add_value_verdict(VALUE_MIN, 1'b0, 8'd1, 8'd2);
      // writes past the register list change nothing
      add_write(CSR_CHECK_MODE, CSR_DATA_W'(MODE_POSIMODULAR));
      add_write(CSR_SPARE_A, 4'hf);
      add_write(CSR_SPARE_B, 4'hf);
      add_value(0);
      add_value(0);
      add_value(0);
      add_value_verdict(-1, 1'b0, 8'd1, 8'd3);
      add_write(CSR_CHECK_MODE, CSR_DATA_W'(MODE_NEGIMODULAR));
      add_value(0);
      add_value(0);
      add_value(5);
      add_value_verdict(0, 1'b0, 8'd2, 8'd3);
      // zero variables acts as one; a single-variable table always holds
      add_write(CSR_NUM_VARIABLES, 4'd0);
      add_value(VALUE_MAX);
      add_value_verdict(VALUE_MIN, 1'b1, 8'd0, 8'd0);
      // shrink the table in the middle of a load: the next item fires the walk
      add_write(CSR_NUM_VARIABLES, 4'd2);
      add_value(1);
      add_value(2);
      add_value(3);
      add_write(CSR_NUM_VARIABLES, 4'd1);
      add_value_verdict(4, 1'b1, 8'd0, 8'd0);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Walk the directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            csr_write(directed_rows[i].index, directed_rows[i].data);
         end else begin
            put_item(directed_rows[i].value);
            if (directed_rows[i].typed && expected_verdicts.size() != 0) begin
               expected_verdicts[expected_verdicts.size() - 1] = directed_rows[i].verdict;
            end
         end
      end

      // Random phases: one setting each, one or more tables per setting
      random_items = 0;
      phase        = 0;
      while (random_items < RANDOM_ITEMS) begin
         phase_mode = MODE_W'($urandom_range(0, 3));
         if (phase == 2) begin
            phase_nvar = NVAR_W'(MAX_VARIABLES_DEFAULT);
         end else if (phase == 6) begin
            phase_nvar = NVAR_W'($urandom_range(MAX_VARIABLES_DEFAULT + 1, 15));
         end else if ($urandom_range(0, 9) == 0) begin
            phase_nvar = '0;
         end else begin
            phase_nvar = NVAR_W'($urandom_range(1, 5));
         end
         csr_write(CSR_CHECK_MODE, CSR_DATA_W'(phase_mode));
         csr_write(CSR_NUM_VARIABLES, phase_nvar);
         if ($urandom_range(0, 7) == 0) begin
            csr_write($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B,
                      CSR_DATA_W'($urandom));
         end
         entries = table_entries(phase_nvar);
         no_idle = ($urandom_range(0, 3) == 0);

         repeat ((entries == TABLE_DEPTH) ? 1 : $urandom_range(2, 6)) begin
            // shape the table: noise, or modular with an optional bump
            noise = ($urandom_range(0, 3) == 0);
            base  = longint'($urandom_range(0, 32'h4000_0000)) - 64'sh2000_0000;
            scale = $urandom_range(0, 26);
            foreach (weight[b]) begin
               weight[b] = longint'($urandom_range(0, 32'd1 << scale));
               if (phase_mode == MODE_NEGIMODULAR ||
                   (phase_mode != MODE_POSIMODULAR && $urandom_range(0, 1))) begin
                  weight[b] = -weight[b];
               end
            end
            bumped    = $urandom_range(0, 1);
            bump_mask = $urandom_range(0, entries - 1);
            bump      = longint'($urandom_range(1, 1000));
            if ($urandom_range(0, 1)) bump = -bump;
            for (int mask = 0; mask < entries; mask++) begin
               if (noise) begin
                  case ($urandom_range(0, 9))
                     0: fval = VALUE_MIN;
                     1: fval = VALUE_MAX;
                     default: fval = $urandom;
                  endcase
               end else begin
                  acc = base;
                  foreach (weight[b]) begin
                     if (mask[b]) acc += weight[b];
                  end
                  if (bumped && mask == bump_mask) acc += bump;
                  fval = acc[FUNC_VALUE_W-1:0];
               end
               put_item(fval);
               random_items++;
            end
            // let every verdict come back now and then
            if ($urandom_range(0, 7) == 0) wait_until_drained();
         end

         // leave a partial load behind for the next setting
         if (entries < TABLE_DEPTH && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, ((entries > 8) ? 8 : entries) - 1)) begin
               put_item($urandom);
               random_items++;
            end
         end
         phase++;
      end

      wait_until_drained();
      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
         $display("set_function_modularity_checker_top_tb OK");
      end else begin
         $display("set_function_modularity_checker_top_tb NOT OK");
      end
      $finish;
   end

endmodule
